// ===== design/r13_pkg.sv =====
package r13_pkg;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharOne  = 8'h31;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharA    = 8'h41;
  localparam logic [7:0] CharC    = 8'h43;

  localparam logic [4:0] Radix   = 5'd13;
  localparam logic [3:0] DecBase = 4'd10;

  localparam logic [1:0] KindAdd = 2'd0;
  localparam logic [1:0] KindSub = 2'd1;

  localparam logic [1:0] OrderLess    = 2'd0;
  localparam logic [1:0] OrderEqual   = 2'd1;
  localparam logic [1:0] OrderGreater = 2'd2;

  typedef struct packed {
    logic       bad;
    logic       neg;
    logic [1:0] ord;
    logic [6:0] len;
    logic       fin;
    logic [7:0] digit;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c inside {[CharZero:CharNine]}) || (c inside {[CharA:CharC]});
  endfunction

  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [7:0] v;
    if (c inside {[CharZero:CharNine]}) begin
      v = c - CharZero;
    end else if (c inside {[CharA:CharC]}) begin
      v = c - CharA + {4'd0, DecBase};
    end else begin
      v = 8'd0;
    end
    digit_val = v[3:0];
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] v);
    if (v < DecBase) begin
      digit_char = CharZero + {4'd0, v};
    end else begin
      digit_char = CharA + {4'd0, v - DecBase};
    end
  endfunction

endpackage

// ===== design/r13_step.sv =====
module r13_step #(
  parameter int MAX_DIGITS = 64,
  parameter int PW         = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [1:0]        kind,
  input  logic [7:0]        digit_a,
  input  logic [7:0]        digit_b,
  input  logic              last_pair,
  output r13_pkg::result_t  res0,
  output r13_pkg::result_t  res1,
  output logic              two_res
);
  import r13_pkg::*;

  logic          carry_r, carry_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] lnz_r, lnz_nxt;
  logic [1:0]    ord_r, ord_nxt;
  logic          bad_r, bad_nxt;

  logic [3:0]    av, bv, d;
  logic [4:0]    sum5, sub5, diff5;
  logic          extra, neg;
  logic [PW-1:0] len_w;

  always_comb begin
    av    = digit_val(digit_a);
    bv    = digit_val(digit_b);
    sum5  = {1'b0, av} + {1'b0, bv} + {4'd0, carry_r};
    sub5  = {1'b0, bv} + {4'd0, carry_r};
    diff5 = 5'd0;
    carry_nxt = carry_r;
    d = 4'd0;
    if (av > bv) begin
      ord_nxt = OrderGreater;
    end else if (av < bv) begin
      ord_nxt = OrderLess;
    end else begin
      ord_nxt = ord_r;
    end
    case (kind)
      KindAdd: begin
        if (sum5 >= Radix) begin
          carry_nxt = 1'b1;
          diff5     = sum5 - Radix;
        end else begin
          carry_nxt = 1'b0;
          diff5     = sum5;
        end
        d = diff5[3:0];
      end
      KindSub: begin
        if ({1'b0, av} < sub5) begin
          carry_nxt = 1'b1;
          diff5     = {1'b0, av} + Radix - sub5;
        end else begin
          carry_nxt = 1'b0;
          diff5     = {1'b0, av} - sub5;
        end
        d = diff5[3:0];
      end
      default: begin
        carry_nxt = carry_r;
        d         = 4'd0;
      end
    endcase
    bad_nxt = bad_r | ~is_digit(digit_a) | ~is_digit(digit_b);
    lnz_nxt = (d != 4'd0) ? pos_r + PW'(1) : lnz_r;
    pos_nxt = (pos_r < PW'(MAX_DIGITS)) ? pos_r + PW'(1) : pos_r;
    extra   = (kind == KindAdd) && carry_nxt;
    neg     = (kind == KindSub) && (ord_nxt == OrderLess);
    len_w   = extra ? pos_r + PW'(2) : lnz_nxt;
    if (len_w == '0) begin
      len_w = PW'(1);
    end
    if (neg) begin
      len_w = '0;
    end
    two_res = last_pair && extra;

    res0       = '0;
    res0.digit = digit_char(d);
    res1       = '0;
    res1.digit = CharOne;
    res1.fin   = 1'b1;
    res1.len   = 7'(len_w);
    res1.ord   = ord_nxt;
    res1.neg   = neg;
    res1.bad   = bad_nxt;
    if (last_pair && !extra) begin
      res0.fin = 1'b1;
      res0.len = 7'(len_w);
      res0.ord = ord_nxt;
      res0.neg = neg;
      res0.bad = bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= 1'b0;
      pos_r   <= '0;
      lnz_r   <= '0;
      ord_r   <= OrderEqual;
      bad_r   <= 1'b0;
    end else if (fire) begin
      if (last_pair) begin
        carry_r <= 1'b0;
        pos_r   <= '0;
        lnz_r   <= '0;
        ord_r   <= OrderEqual;
        bad_r   <= 1'b0;
      end else begin
        carry_r <= carry_nxt;
        pos_r   <= pos_nxt;
        lnz_r   <= lnz_nxt;
        ord_r   <= ord_nxt;
        bad_r   <= bad_nxt;
      end
    end
  end

endmodule

// ===== design/radix13_digit_serial_addsub_compare_top.sv =====
// Channel  Dir  Payload                                              Marker
// in_      in   tdata: digit_a, digit_b; tuser: kind                 tlast = last_pair
// out_     out  tdata: result_digit, result_length, order, negative, tlast = final_res
//               bad_digit
//
// One item a cycle: an input register feeds the digit unit, which writes
// one or two results into a four-entry output queue in the same cycle.
// An accepted item passes through the input register and then the output queue before its result is shown.
// The unit stalls while the queue has fewer than two free entries.
// Synchronous active-low reset clears carry, counters, order and the queue.
module radix13_digit_serial_addsub_compare_top #(
  parameter int MAX_DIGITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // digit_a[7:0], digit_b[15:8]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // result_digit[7:0], result_length[14:8],
                                  // order[16:15], negative[17], bad_digit[18]
  output logic        out_tlast
);
  import r13_pkg::*;

  localparam int PW        = $clog2(MAX_DIGITS + 3);
  localparam int FifoDepth = 4;
  localparam int FAW       = $clog2(FifoDepth);
  localparam int FCW       = $clog2(FifoDepth + 1);

  logic           in_valid_r;
  logic [1:0]     kind_r;
  logic [7:0]     a_r, b_r;
  logic           last_r;
  logic           proc;
  logic           pop;

  result_t        res0, res1, head;
  logic           two_res;

  result_t        mem [FifoDepth];
  logic [FAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FCW-1:0] count_r, count_nxt;

  assign proc      = in_valid_r && (count_r <= FCW'(FifoDepth - 2));
  assign in_tready = !in_valid_r || proc;
  assign pop       = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      kind_r <= in_tuser;
      a_r    <= in_tdata[7:0];
      b_r    <= in_tdata[15:8];
      last_r <= in_tlast;
    end
  end

  r13_step #(
    .MAX_DIGITS (MAX_DIGITS),
    .PW         (PW)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (proc),
    .kind      (kind_r),
    .digit_a   (a_r),
    .digit_b   (b_r),
    .last_pair (last_r),
    .res0      (res0),
    .res1      (res1),
    .two_res   (two_res)
  );

  always_comb begin
    count_nxt = count_r;
    if (proc) begin
      count_nxt = count_nxt + (two_res ? FCW'(2) : FCW'(1));
    end
    if (pop) begin
      count_nxt = count_nxt - FCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (proc) begin
        wr_ptr_r <= wr_ptr_r + (two_res ? FAW'(2) : FAW'(1));
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      mem[wr_ptr_r] <= res0;
      if (two_res) begin
        mem[wr_ptr_r + FAW'(1)] <= res1;
      end
    end
  end

  assign head       = mem[rd_ptr_r];
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = {5'd0, head.bad, head.neg, head.ord, head.len, head.digit};
  assign out_tlast  = head.fin;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FCW'(FifoDepth))
    else $error("output queue overfilled");

  a_room_on_proc: assert property (@(posedge clk) disable iff (!rst_n)
    proc |-> (count_r <= FCW'(FifoDepth - 2)))
    else $error("item processed without room for two results");

  a_neg_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[17]) |-> (out_tdata[14:8] == 7'd0))
    else $error("negative result with nonzero length");

  a_nonfinal_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[18:8] == 11'd0))
    else $error("summary fields set on a non-final item");
`endif

endmodule

// ===== dv/r13_result_checker.sv =====
module r13_result_checker #(
  parameter int MAX_DIGITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // digit_a[7:0], digit_b[15:8]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // result_digit[7:0], result_length[14:8],
                                  // order[16:15], negative[17], bad_digit[18]
  input  logic        out_tlast,
  output int          errors,
  output int          pending
);
  import r13_pkg::*;

  logic       carry_q;
  logic [6:0] position_q;
  logic [6:0] nonzero_pos_q;
  logic [1:0] order_q;
  logic       bad_seen_q;
  result_t    expected_results[$];
  int         results_seen;

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
  end

  function automatic logic [3:0] char_value(input logic [7:0] c, output logic bad);
    logic [7:0] v;
    bad = 1'b0;
    v = 8'd0;
    if (c >= CharZero && c <= CharNine) begin
      v = c - CharZero;
    end else if (c >= CharA && c <= CharC) begin
      v = c - CharA + 8'd10;
    end else begin
      bad = 1'b1;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] value_char(input logic [3:0] v);
    return (v <= 4'd9) ? CharZero + 8'(v) : CharC - 8'(4'd12 - v);
  endfunction

  task automatic clear_number();
    carry_q = 1'b0;
    position_q = '0;
    nonzero_pos_q = '0;
    order_q = OrderEqual;
    bad_seen_q = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("checker: %s mismatch on result %0d: got %0h, expected %0h",
             what, results_seen, got, want);
  endtask

  task automatic predict_digits(input logic [1:0] kind, input logic [7:0] ca,
                                input logic [7:0] cb, input logic last);
    logic       bad_a;
    logic       bad_b;
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] d;
    logic [4:0] s;
    logic [6:0] len;
    logic       neg;
    logic       extra;
    result_t    r;
    a = char_value(ca, bad_a);
    b = char_value(cb, bad_b);
    if (bad_a || bad_b) bad_seen_q = 1'b1;
    if (a > b) begin
      order_q = OrderGreater;
    end else if (a < b) begin
      order_q = OrderLess;
    end
    d = 4'd0;
    if (kind == KindAdd) begin
      s = {1'b0, a} + {1'b0, b} + {4'd0, carry_q};
      if (s >= Radix) begin
        carry_q = 1'b1;
        s = s - Radix;
      end else begin
        carry_q = 1'b0;
      end
      d = s[3:0];
    end else if (kind == KindSub) begin
      s = {1'b0, b} + {4'd0, carry_q};
      if ({1'b0, a} < s) begin
        carry_q = 1'b1;
        s = {1'b0, a} + Radix - s;
      end else begin
        carry_q = 1'b0;
        s = {1'b0, a} - s;
      end
      d = s[3:0];
    end
    if (d != 4'd0) nonzero_pos_q = position_q + 7'd1;
    r = '0;
    r.digit = value_char(d);
    if (!last) begin
      expected_results.push_back(r);
      if (position_q < MAX_DIGITS) position_q++;
    end else begin
      len = nonzero_pos_q;
      neg = (kind == KindSub) && (order_q == OrderLess);
      extra = (kind == KindAdd) && carry_q;
      if (extra) len = position_q + 7'd2;
      if (len == 7'd0) len = 7'd1;
      if (neg) len = 7'd0;
      if (extra) begin
        expected_results.push_back(r);
        r.digit = CharOne;
      end
      r.fin = 1'b1;
      r.len = len;
      r.ord = order_q;
      r.neg = neg;
      r.bad = bad_seen_q;
      expected_results.push_back(r);
      clear_number();
    end
  endtask

  task automatic check_result();
    result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected item", int'(out_tdata), 0);
      return;
    end
    want = expected_results.pop_front();
    if (out_tdata[7:0] !== want.digit) begin
      report_mismatch("digit", int'(out_tdata[7:0]), int'(want.digit));
    end
    if (out_tlast !== want.fin) begin
      report_mismatch("final", int'(out_tlast), int'(want.fin));
    end
    if (out_tdata[14:8] !== want.len) begin
      report_mismatch("length", int'(out_tdata[14:8]), int'(want.len));
    end
    if (out_tdata[16:15] !== want.ord) begin
      report_mismatch("order", int'(out_tdata[16:15]), int'(want.ord));
    end
    if (out_tdata[17] !== want.neg) begin
      report_mismatch("negative", int'(out_tdata[17]), int'(want.neg));
    end
    if (out_tdata[18] !== want.bad) begin
      report_mismatch("bad digit", int'(out_tdata[18]), int'(want.bad));
    end
    if (out_tdata[23:19] !== 5'd0) begin
      report_mismatch("padding", int'(out_tdata[23:19]), 0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_number();
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) begin
        predict_digits(in_tuser, in_tdata[7:0], in_tdata[15:8], in_tlast);
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== dv/radix13_digit_serial_addsub_compare_top_tb.sv =====
module radix13_digit_serial_addsub_compare_top_tb;
  import r13_pkg::*;

  localparam int         MaxDigits  = 64;
  localparam int         ItemTarget = 1850;
  localparam int         LongHold   = 100;
  localparam logic [1:0] KindCmp    = 2'd2;
  localparam logic [1:0] KindCmpAlt = 2'd3;

  localparam int StyleRandom  = 0;
  localparam int StyleEqual   = 1;
  localparam int StyleShortB  = 2;
  localparam int StyleShortA  = 3;
  localparam int StyleChain   = 4;
  localparam int StyleNoise   = 5;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;
  int          errors;
  int          pending;

  bit in_gaps_on;
  bit out_gaps_on;
  bit long_hold;
  int items_sent;

  radix13_digit_serial_addsub_compare_top #(
    .MAX_DIGITS(MaxDigits)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  r13_result_checker #(
    .MAX_DIGITS(MaxDigits)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [7:0] digit_of(input int v);
    return (v < 10) ? CharZero + 8'(v) : CharA + 8'(v - 10);
  endfunction

  function automatic logic [1:0] pick_kind();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return KindAdd;
    if (r < 15) return KindSub;
    if (r < 19) return KindCmp;
    return KindCmpAlt;
  endfunction

  task automatic send_pair(input logic [1:0] kind, input logic [7:0] a, input logic [7:0] b,
                           input logic last);
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    in_tuser  <= kind;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (in_gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_number(input int len, input int style, input logic [1:0] kind);
    logic [1:0] pair_kind;
    logic [7:0] a;
    logic [7:0] b;
    int         cut;
    cut = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      a = digit_of($urandom_range(0, 12));
      b = digit_of($urandom_range(0, 12));
      case (style)
        StyleEqual: begin
          b = a;
        end
        StyleShortB: begin
          if (i >= cut) b = CharZero;
        end
        StyleShortA: begin
          if (i >= cut) a = CharZero;
        end
        StyleChain: begin
          a = (kind == KindAdd) ? CharC : CharZero;
          b = (kind == KindAdd) ? CharC : ((i == 0) ? CharOne : CharZero);
        end
        StyleNoise: begin
          a = 8'($urandom_range(0, 255));
          b = 8'($urandom_range(0, 255));
        end
        default: begin
        end
      endcase
      if ($urandom_range(0, 49) == 0) a = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 49) == 0) b = 8'($urandom_range(0, 255));
      pair_kind = kind;
      if ($urandom_range(0, 39) == 0) pair_kind = 2'($urandom_range(0, 3));
      send_pair(pair_kind, a, b, i == len - 1);
    end
  endtask

  initial begin
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        long_hold = 1'b0;
        out_tready <= 1'b1;
      end else if (out_gaps_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int  len;
    int  style;
    bit  hold_done;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    in_tlast   <= 1'b0;
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    long_hold   = 1'b0;
    hold_done   = 1'b0;
    items_sent  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // carry out of the top pair
    send_pair(KindAdd, CharC, CharOne, 1'b1);
    send_pair(KindAdd, CharC, CharC, 1'b0);
    send_pair(KindAdd, CharC, CharC, 1'b1);
    send_pair(KindAdd, CharZero, CharZero, 1'b1);
    send_pair(KindSub, digit_of(5), digit_of(5), 1'b1);
    send_pair(KindSub, digit_of(3), digit_of(7), 1'b1);
    // borrow across pairs
    send_pair(KindSub, CharZero, CharOne, 1'b0);
    send_pair(KindSub, CharOne, CharZero, 1'b1);
    send_pair(KindCmp, CharC, CharZero, 1'b1);
    send_pair(KindCmp, CharZero, CharC, 1'b1);
    send_pair(KindCmp, CharNine, CharNine, 1'b0);
    send_pair(KindCmp, CharA, CharA, 1'b1);
    // invalid characters, including neighbours of the digit ranges
    send_pair(KindAdd, 8'h00, 8'hFF, 1'b1);
    send_pair(KindAdd, 8'h2F, 8'h3A, 1'b0);
    send_pair(KindAdd, 8'h40, 8'h44, 1'b1);
    send_pair(KindSub, 8'h5A, CharOne, 1'b0);
    send_pair(KindSub, CharNine, CharZero, 1'b1);
    send_pair(KindCmpAlt, digit_of(7), digit_of(2), 1'b1);
    // kind changes inside one number
    send_pair(KindAdd, CharC, CharOne, 1'b0);
    send_pair(KindCmp, digit_of(4), digit_of(6), 1'b0);
    send_pair(KindSub, CharOne, CharZero, 1'b1);

    // position counter saturation
    send_number(70, StyleChain, KindAdd);
    send_number(68, StyleRandom, KindSub);

    while (items_sent < ItemTarget) begin
      if (!hold_done && items_sent > 600) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (items_sent > ItemTarget - 250) begin
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
      end
      style = $urandom_range(0, 9);
      if (style > StyleNoise) style = StyleRandom;
      if ($urandom_range(0, 199) == 0) begin
        len = $urandom_range(65, 72);
      end else if ($urandom_range(0, 5) == 0) begin
        len = $urandom_range(9, 20);
      end else begin
        len = $urandom_range(1, 8);
      end
      send_number(len, style, pick_kind());
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
